### hw/rtl/kfsl_pkg.sv
package kfsl_pkg;

    localparam int MAX_KEYS = 32;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int COUNT_W  = IDX_W + 1;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int CNT_W    = $clog2(TIME_W);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_SET_TIME  = 3'd1,
        OP_ADD_TIME  = 3'd2,
        OP_QUERY_AT  = 3'd3,
        OP_QUERY_CUR = 3'd4
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd1;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [TIME_W-1:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [IDX_W-1:0]         prev_index;
        logic [IDX_W-1:0]         next_index;
        logic [FRAC_W-1:0]        fraction;
        logic signed [TIME_W-1:0] playback_time;
        logic [COUNT_W-1:0]       key_count;
    } out_item_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SET_FULL,
        CMD_SET_EMPTY,
        CMD_INS_INIT,
        CMD_INS_READ,
        CMD_INS_SHIFT,
        CMD_INS_PLACE,
        CMD_SET_T,
        CMD_ADD_T,
        CMD_COMMIT,
        CMD_CLAMP,
        CMD_MOD_INIT,
        CMD_MOD_STEP,
        CMD_MOD_APPLY,
        CMD_QRY_INIT,
        CMD_SRCH_INIT,
        CMD_SRCH_READ,
        CMD_SRCH_UPD,
        CMD_READ_T2,
        CMD_SET_T2,
        CMD_READ_T1,
        CMD_SET_T1,
        CMD_FRAC_START,
        CMD_FRAC_STEP,
        CMD_OUT_LOAD
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    op_valid;
        logic    full;
        logic    empty;
        logic    idx_zero;
        logic    ins_gt;
        logic    t_eq_cur;
        logic    loop;
        logic    len_zero;
        logic    need_mod;
        logic    mod_last;
        logic    srch_done;
        logic    frac_trivial;
        logic    frac_last;
    } dp_stat_t;

endpackage

### hw/rtl/keyframe_segment_locator.sv
// Keyframe segment locator.
// The s_ channel takes one item per operation: an opcode and a signed Q16.16
// time value. Insert places a key time into a sorted table of up to 32 keys,
// set time and add time update the playback time, and the two queries return
// the bracketing keyframe indices and the Q0.16 fraction between them.
// Every item produces exactly one result item on the m_ channel.
// The cfg_ channel writes the animation length (index 0) and the loop enable
// (index 1); it is always ready. It is to be used only while the block is
// idle; the block itself does not enforce this. Items are handled one at a
// time. An insert moves each larger key up one place before placing the new
// key. A set or add time that changes the time passes through the 32-step
// modulo unit when looping is on and the length is nonzero. A query runs a
// binary search on the single-read key memory (up to 6 probes on a full
// table) after first reducing the time by the length where it exceeds it.
// After reset the table is empty, playback time is zero, the length is 1.0
// and looping is on; the key memory needs no clearing. Results sit in an
// output register, so a new item is accepted while the last result waits;
// a stalled receiver holds the next result back until the register frees.
module keyframe_segment_locator
    import kfsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes land directly in the datapath registers.
    assign cfg_ready = 1'b1;

    kfsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kfsl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### hw/rtl/kfsl_ram.sv
module kfsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/kfsl_dp.sv
module kfsl_dp
    import kfsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  in_item_t             s_data,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    logic [LEN_W-1:0]         len_reg;
    logic                     loop_reg;
    logic [2:0]               op_reg;
    logic signed [TIME_W-1:0] tv_reg;
    logic signed [TIME_W-1:0] cur_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [TIME_W-1:0] t_reg;
    logic [COUNT_W-1:0]       idx_reg;
    logic [COUNT_W-1:0]       lo_reg;
    logic [COUNT_W-1:0]       hi_reg;
    logic [COUNT_W-1:0]       mid_reg;
    logic [TIME_W-1:0]        dvd_reg;
    logic [TIME_W-1:0]        mrem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [TIME_W:0]   t2_reg;
    logic signed [TIME_W-1:0] t1_reg;
    logic [TIME_W+2:0]        frem_reg;
    logic [TIME_W+1:0]        den_reg;
    logic [1:0]               status_reg;
    logic [IDX_W-1:0]         prev_reg;
    logic [IDX_W-1:0]         next_reg;
    logic [FRAC_W-1:0]        frac_reg;
    out_item_t                out_reg;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [TIME_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [TIME_W-1:0]        ram_rdata;
    logic signed [TIME_W-1:0] key_rd;

    logic signed [TIME_W:0]   sum_wide;
    logic signed [TIME_W-1:0] sum_sat;
    logic [COUNT_W:0]         mid_sum;
    logic [COUNT_W-1:0]       mid_calc;
    logic                     wrap;
    logic [TIME_W:0]          mtrial;
    logic [TIME_W:0]          len_ext;
    logic signed [TIME_W+1:0] t_x;
    logic signed [TIME_W+1:0] t1_x;
    logic signed [TIME_W+1:0] t2_x;
    logic signed [TIME_W+1:0] dnum;
    logic signed [TIME_W+1:0] dden;
    logic [TIME_W+1:0]        num_mag;
    logic [TIME_W+1:0]        den_mag;
    logic                     frac_sat;
    logic [TIME_W+2:0]        frem_dbl;
    logic [TIME_W:0]          t_minus1;

    assign key_rd   = $signed(ram_rdata);
    assign len_ext  = {2'b00, len_reg};
    assign sum_wide = {cur_reg[TIME_W-1], cur_reg} + {tv_reg[TIME_W-1], tv_reg};
    assign sum_sat  = (sum_wide[TIME_W] != sum_wide[TIME_W-1])
                    ? (sum_wide[TIME_W] ? T_MIN : T_MAX) : sum_wide[TIME_W-1:0];
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[COUNT_W:1];
    assign wrap     = (lo_reg == count_reg);
    assign mtrial   = {mrem_reg, dvd_reg[TIME_W-1]};
    assign t_minus1 = {t_reg[TIME_W-1], t_reg} - 1'b1;

    assign t_x     = {{2{t_reg[TIME_W-1]}}, t_reg};
    assign t1_x    = {{2{t1_reg[TIME_W-1]}}, t1_reg};
    assign t2_x    = {t2_reg[TIME_W], t2_reg};
    assign dnum    = t_x - t1_x;
    assign dden    = t2_x - t1_x;
    assign num_mag = dnum[TIME_W+1] ? -dnum : dnum;
    assign den_mag = dden[TIME_W+1] ? -dden : dden;
    assign frac_sat = (t1_x != t2_x) && (num_mag != '0)
                    && (dnum[TIME_W+1] == dden[TIME_W+1]) && (num_mag >= den_mag);
    assign frem_dbl = {frem_reg[TIME_W+1:0], 1'b0};

    always_comb begin
        stat              = '0;
        stat.op           = opcode_t'(op_reg);
        stat.op_valid     = (op_reg <= 3'(OP_QUERY_CUR));
        stat.full         = (count_reg >= COUNT_W'(MAX_KEYS));
        stat.empty        = (count_reg == '0);
        stat.idx_zero     = (idx_reg == '0);
        stat.ins_gt       = (key_rd > tv_reg);
        stat.t_eq_cur     = (t_reg == cur_reg);
        stat.loop         = loop_reg;
        stat.len_zero     = (len_reg == '0);
        stat.need_mod     = (len_reg != '0) && (t_reg > $signed({1'b0, len_reg}));
        stat.mod_last     = (cnt_reg == CNT_W'(TIME_W - 1));
        stat.srch_done    = (lo_reg == hi_reg);
        stat.frac_trivial = (t1_x == t2_x) || (num_mag == '0)
                          || (dnum[TIME_W+1] != dden[TIME_W+1]) || (num_mag >= den_mag);
        stat.frac_last    = (cnt_reg == CNT_W'(FRAC_W - 1));
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        case (cmd)
            CMD_INS_READ:  ram_raddr = IDX_W'(idx_reg - 1'b1);
            CMD_INS_SHIFT: ram_we = 1'b1;
            CMD_INS_PLACE: begin
                ram_we    = 1'b1;
                ram_wdata = tv_reg;
            end
            CMD_SRCH_READ: ram_raddr = mid_calc[IDX_W-1:0];
            CMD_READ_T2:   ram_raddr = wrap ? '0 : lo_reg[IDX_W-1:0];
            CMD_READ_T1:   ram_raddr = prev_reg;
            default:       ram_raddr = '0;
        endcase
    end

    kfsl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_keys (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LEN_W'(65536);
            loop_reg  <= 1'b1;
            cur_reg   <= '0;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_ANIM_LENGTH) begin
                    len_reg <= cfg_data[LEN_W-1:0];
                end else if (cfg_index == CFG_LOOP_ENABLE) begin
                    loop_reg <= cfg_data[0];
                end
            end
            case (cmd)
                CMD_LOAD: begin
                    op_reg     <= s_data.opcode;
                    tv_reg     <= s_data.time_value;
                    status_reg <= ST_OK;
                    prev_reg   <= '0;
                    next_reg   <= '0;
                    frac_reg   <= '0;
                end
                CMD_SET_FULL:  status_reg <= ST_FULL;
                CMD_SET_EMPTY: status_reg <= ST_EMPTY;
                CMD_INS_INIT:  idx_reg <= count_reg;
                CMD_INS_SHIFT: idx_reg <= idx_reg - 1'b1;
                CMD_INS_PLACE: begin
                    prev_reg  <= idx_reg[IDX_W-1:0];
                    count_reg <= count_reg + 1'b1;
                end
                CMD_SET_T:  t_reg <= tv_reg;
                CMD_ADD_T:  t_reg <= sum_sat;
                CMD_COMMIT: cur_reg <= t_reg;
                CMD_CLAMP: begin
                    if (t_reg < 0) begin
                        cur_reg <= '0;
                    end else if (t_reg > $signed({1'b0, len_reg})) begin
                        cur_reg <= {1'b0, len_reg};
                    end else begin
                        cur_reg <= t_reg;
                    end
                end
                CMD_MOD_INIT: begin
                    mrem_reg <= '0;
                    cnt_reg  <= '0;
                    if (op_reg == 3'(OP_QUERY_AT) || op_reg == 3'(OP_QUERY_CUR)) begin
                        dvd_reg <= t_minus1[TIME_W-1:0];
                    end else begin
                        dvd_reg <= t_reg[TIME_W-1] ? -t_reg : t_reg;
                    end
                end
                CMD_MOD_STEP: begin
                    dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (mtrial >= len_ext) begin
                        mrem_reg <= TIME_W'(mtrial - len_ext);
                    end else begin
                        mrem_reg <= mtrial[TIME_W-1:0];
                    end
                end
                CMD_MOD_APPLY: begin
                    if (op_reg == 3'(OP_QUERY_AT) || op_reg == 3'(OP_QUERY_CUR)) begin
                        t_reg <= mrem_reg + 1'b1;
                    end else if (t_reg[TIME_W-1] && mrem_reg != '0) begin
                        cur_reg <= TIME_W'(len_ext) - mrem_reg;
                    end else begin
                        cur_reg <= mrem_reg;
                    end
                end
                CMD_QRY_INIT: t_reg <= (op_reg == 3'(OP_QUERY_AT)) ? tv_reg : cur_reg;
                CMD_SRCH_INIT: begin
                    lo_reg <= '0;
                    hi_reg <= count_reg;
                end
                CMD_SRCH_READ: mid_reg <= mid_calc;
                CMD_SRCH_UPD: begin
                    if (key_rd < t_reg) begin
                        lo_reg <= mid_reg + 1'b1;
                    end else begin
                        hi_reg <= mid_reg;
                    end
                end
                CMD_SET_T2: begin
                    if (wrap) begin
                        t2_reg   <= $signed(len_ext) + {key_rd[TIME_W-1], key_rd};
                        next_reg <= '0;
                        prev_reg <= IDX_W'(count_reg - 1'b1);
                    end else begin
                        t2_reg   <= {key_rd[TIME_W-1], key_rd};
                        next_reg <= lo_reg[IDX_W-1:0];
                        if (lo_reg != '0 && t_reg < key_rd) begin
                            prev_reg <= IDX_W'(lo_reg - 1'b1);
                        end else begin
                            prev_reg <= lo_reg[IDX_W-1:0];
                        end
                    end
                end
                CMD_SET_T1: t1_reg <= key_rd;
                CMD_FRAC_START: begin
                    frem_reg <= {1'b0, num_mag};
                    den_reg  <= den_mag;
                    cnt_reg  <= '0;
                    frac_reg <= frac_sat ? '1 : '0;
                end
                CMD_FRAC_STEP: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (frem_dbl >= {1'b0, den_reg}) begin
                        frem_reg <= frem_dbl - {1'b0, den_reg};
                        frac_reg <= {frac_reg[FRAC_W-2:0], 1'b1};
                    end else begin
                        frem_reg <= frem_dbl;
                        frac_reg <= {frac_reg[FRAC_W-2:0], 1'b0};
                    end
                end
                CMD_OUT_LOAD: begin
                    out_reg.status        <= status_reg;
                    out_reg.prev_index    <= prev_reg;
                    out_reg.next_index    <= next_reg;
                    out_reg.fraction      <= frac_reg;
                    out_reg.playback_time <= cur_reg;
                    out_reg.key_count     <= count_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_data = out_reg;

    // Checks on the key table and the search window.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_KEYS))
        else $error("key count above table depth");

    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    a_write_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (op_reg == 3'(OP_INSERT)))
        else $error("key table written outside an insert");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("key count moved by other than one");

endmodule

### hw/rtl/kfsl_ctrl.sv
module kfsl_ctrl
    import kfsl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_INS_RD, S_INS_CMP, S_PLAY, S_MOD, S_MOD_END,
        S_QPREP, S_SRCH_INIT, S_SRCH, S_SRCH_CMP, S_GOT_T2, S_FETCH1,
        S_GOT_T1, S_FCHK, S_FDIV, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.op_valid) begin
                    state_next = S_FINISH;
                end else begin
                    case (stat.op)
                        OP_INSERT: begin
                            cmd        = stat.full ? CMD_SET_FULL : CMD_INS_INIT;
                            state_next = stat.full ? S_FINISH : S_INS_RD;
                        end
                        OP_SET_TIME: begin
                            cmd        = CMD_SET_T;
                            state_next = S_PLAY;
                        end
                        OP_ADD_TIME: begin
                            cmd        = CMD_ADD_T;
                            state_next = S_PLAY;
                        end
                        default: begin
                            cmd        = CMD_QRY_INIT;
                            state_next = S_QPREP;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (stat.idx_zero) begin
                    cmd        = CMD_INS_PLACE;
                    state_next = S_FINISH;
                end else begin
                    cmd        = CMD_INS_READ;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (stat.ins_gt) begin
                    cmd        = CMD_INS_SHIFT;
                    state_next = S_INS_RD;
                end else begin
                    cmd        = CMD_INS_PLACE;
                    state_next = S_FINISH;
                end
            end
            S_PLAY: begin
                if (stat.t_eq_cur) begin
                    state_next = S_FINISH;
                end else if (!stat.loop) begin
                    cmd        = CMD_CLAMP;
                    state_next = S_FINISH;
                end else if (stat.len_zero) begin
                    cmd        = CMD_COMMIT;
                    state_next = S_FINISH;
                end else begin
                    cmd        = CMD_MOD_INIT;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                cmd = CMD_MOD_STEP;
                if (stat.mod_last) begin
                    state_next = S_MOD_END;
                end
            end
            S_MOD_END: begin
                cmd = CMD_MOD_APPLY;
                if (stat.op == OP_QUERY_AT || stat.op == OP_QUERY_CUR) begin
                    state_next = S_SRCH_INIT;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_QPREP: begin
                if (stat.empty) begin
                    cmd        = CMD_SET_EMPTY;
                    state_next = S_FINISH;
                end else if (stat.need_mod) begin
                    cmd        = CMD_MOD_INIT;
                    state_next = S_MOD;
                end else begin
                    cmd        = CMD_SRCH_INIT;
                    state_next = S_SRCH;
                end
            end
            S_SRCH_INIT: begin
                cmd        = CMD_SRCH_INIT;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                if (stat.srch_done) begin
                    cmd        = CMD_READ_T2;
                    state_next = S_GOT_T2;
                end else begin
                    cmd        = CMD_SRCH_READ;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                cmd        = CMD_SRCH_UPD;
                state_next = S_SRCH;
            end
            S_GOT_T2: begin
                cmd        = CMD_SET_T2;
                state_next = S_FETCH1;
            end
            S_FETCH1: begin
                cmd        = CMD_READ_T1;
                state_next = S_GOT_T1;
            end
            S_GOT_T1: begin
                cmd        = CMD_SET_T1;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                cmd        = CMD_FRAC_START;
                state_next = stat.frac_trivial ? S_FINISH : S_FDIV;
            end
            S_FDIV: begin
                cmd = CMD_FRAC_STEP;
                if (stat.frac_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd        = CMD_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd == CMD_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_LOAD) |-> (state_reg == S_IDLE))
        else $error("item loaded while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_OUT_LOAD) |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_finish_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && state_next == S_IDLE) |=> m_valid_reg)
        else $error("finished item produced no result");

endmodule
